// File: hdl/sdll_pkg.sv
package sdll_pkg;

  // Field and table geometry
  localparam int unsigned SLOT_BITS    = 8;
  localparam int unsigned DATA_BITS    = 32;
  localparam int unsigned NUM_SLOTS    = 256;
  localparam int unsigned CAPACITY     = 255;
  localparam int unsigned USABLE_SLOTS = (CAPACITY > 255) ? 255 : CAPACITY;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIRST  = 2'd2;
  localparam logic [1:0] REQ_NEXT   = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BAD_SLOT = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

endpackage

// File: hdl/slot_doubly_linked_list_free_stack_unit.sv
// Doubly linked list of data entries kept in a slot table, slot 0 is null.
// Input channel (in_valid_i / in_ready_o) takes one request: insert at tail,
// remove a slot, read the first entry or read the successor of a slot.
// Output channel (out_valid_o / out_ready_i) gives exactly one result per
// request: slot, data, links, entry count after the request and a status.
// Freed slots go on a LIFO free stack chained through the next links.
// Requests are worked one at a time; a rejected request goes straight to
// its result. An insert pops the free stack if it is not empty, else takes
// a never-used slot, then writes the new node and, unless the list was
// empty, links the old tail forward to it. A read next follows the next
// link, then reads the successor unless it hits the end of the list.
// These steps come from the single-port link memories with registered read
// data: a remove reads the node, writes the neighbor links, then writes
// the free-stack link into the same next-link memory.
// The result appears in the same cycle as the next request can be taken.
// A finished result waits in an output register; the next request is
// accepted and worked while it waits, and only the hand-over of its own
// result stalls until the receiver takes the previous one. Reset empties
// the list and the free stack at once; the link and data memories need no
// clearing since only links and data written since reset are used.
module slot_doubly_linked_list_free_stack_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  slot_in_i,
  input  logic [31:0] data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  slot_out_o,
  output logic [31:0] data_out_o,
  output logic [7:0]  prev_out_o,
  output logic [7:0]  next_out_o,
  output logic [7:0]  list_count_o,
  output logic [1:0]  status_o
);

  localparam int unsigned SB = sdll_pkg::SLOT_BITS;
  localparam int unsigned DB = sdll_pkg::DATA_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_POP  = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_INS_TAIL = 4'd3;
  localparam logic [3:0] S_RM_RD    = 4'd4;
  localparam logic [3:0] S_RM_PUSH  = 4'd5;
  localparam logic [3:0] S_NX_RD    = 4'd6;
  localparam logic [3:0] S_RD_OUT   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  // Link and data memories
  logic [SB-1:0] nx_mem [sdll_pkg::NUM_SLOTS];
  logic [SB-1:0] pv_mem [sdll_pkg::NUM_SLOTS];
  logic [DB-1:0] dt_mem [sdll_pkg::NUM_SLOTS];

  logic [SB-1:0] nx_addr, pv_addr, dt_addr;
  logic          nx_we, pv_we, dt_we;
  logic [SB-1:0] nx_wdata, pv_wdata;
  logic [DB-1:0] dt_wdata;
  logic [SB-1:0] nx_rdata_q, pv_rdata_q;
  logic [DB-1:0] dt_rdata_q;

  // Control state
  logic [3:0]                   state_q, state_d;
  logic [SB-1:0]                head_q, head_d, tail_q, tail_d;
  logic [SB-1:0]                count_q, count_d, hw_q, hw_d;
  logic [SB-1:0]                free_top_q, free_top_d;
  logic [sdll_pkg::NUM_SLOTS-1:0] in_list_q, in_list_d;
  logic                         out_valid_q, out_valid_d;

  // Request and result holding
  logic [SB-1:0] slot_q, slot_d, n_q, n_d, ptail_q, ptail_d;
  logic [DB-1:0] din_q, din_d;
  logic [SB-1:0] res_slot_q, res_slot_d, res_prev_q, res_prev_d;
  logic [SB-1:0] res_next_q, res_next_d, res_count_q, res_count_d;
  logic [DB-1:0] res_data_q, res_data_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [SB-1:0] o_slot_q, o_slot_d, o_prev_q, o_prev_d;
  logic [SB-1:0] o_next_q, o_next_d, o_count_q, o_count_d;
  logic [DB-1:0] o_data_q, o_data_d;
  logic [1:0]    o_status_q, o_status_d;

  logic load_out;

  // Next-link memory: one port, read data registered
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      nx_mem[nx_addr] <= nx_wdata;
    end
    nx_rdata_q <= nx_mem[nx_addr];
  end

  // Previous-link memory
  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      pv_mem[pv_addr] <= pv_wdata;
    end
    pv_rdata_q <= pv_mem[pv_addr];
  end

  // Entry data memory
  always_ff @(posedge clk_i) begin
    if (dt_we) begin
      dt_mem[dt_addr] <= dt_wdata;
    end
    dt_rdata_q <= dt_mem[dt_addr];
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequence each request through the memories
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    hw_d         = hw_q;
    free_top_d   = free_top_q;
    in_list_d    = in_list_q;
    slot_d       = slot_q;
    n_d          = n_q;
    ptail_d      = ptail_q;
    din_d        = din_q;
    res_slot_d   = res_slot_q;
    res_data_d   = res_data_q;
    res_prev_d   = res_prev_q;
    res_next_d   = res_next_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;

    nx_addr  = slot_in_i;
    pv_addr  = slot_in_i;
    dt_addr  = slot_in_i;
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    dt_we    = 1'b0;
    nx_wdata = '0;
    pv_wdata = '0;
    dt_wdata = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          slot_d       = slot_in_i;
          din_d        = data_in_i;
          // Rejected requests answer with a null slot
          res_slot_d   = '0;
          res_data_d   = '0;
          res_prev_d   = '0;
          res_next_d   = '0;
          res_count_d  = count_q;
          case (req_type_i)
            sdll_pkg::REQ_INSERT: begin
              if (free_top_q != '0) begin
                nx_addr = free_top_q;
                state_d = S_INS_POP;
              end else if (hw_q < SB'(sdll_pkg::USABLE_SLOTS)) begin
                hw_d    = hw_q + 1'b1;
                n_d     = hw_q + 1'b1;
                state_d = S_INS_WR;
              end else begin
                res_status_d = sdll_pkg::STAT_FULL;
                state_d      = S_DONE;
              end
            end
            sdll_pkg::REQ_REMOVE: begin
              if (slot_in_i == '0 || !in_list_q[slot_in_i]) begin
                res_status_d = sdll_pkg::STAT_BAD_SLOT;
                state_d      = S_DONE;
              end else begin
                state_d = S_RM_RD;
              end
            end
            sdll_pkg::REQ_FIRST: begin
              if (count_q == '0 || head_q == '0) begin
                res_status_d = sdll_pkg::STAT_EMPTY;
                state_d      = S_DONE;
              end else begin
                nx_addr = head_q;
                pv_addr = head_q;
                dt_addr = head_q;
                slot_d  = head_q;
                state_d = S_RD_OUT;
              end
            end
            sdll_pkg::REQ_NEXT: begin
              if (slot_in_i == '0 || !in_list_q[slot_in_i]) begin
                res_status_d = sdll_pkg::STAT_BAD_SLOT;
                state_d      = S_DONE;
              end else begin
                state_d = S_NX_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Pop the free stack
      S_INS_POP: begin
        n_d        = free_top_q;
        free_top_d = nx_rdata_q;
        state_d    = S_INS_WR;
      end

      // Write the new node and append it at the tail
      S_INS_WR: begin
        nx_we    = 1'b1;
        nx_addr  = n_q;
        nx_wdata = '0;
        pv_we    = 1'b1;
        pv_addr  = n_q;
        pv_wdata = (count_q == '0) ? '0 : tail_q;
        dt_we    = 1'b1;
        dt_addr  = n_q;
        dt_wdata = din_q;
        res_slot_d   = n_q;
        res_data_d   = din_q;
        res_prev_d   = (count_q == '0) ? '0 : tail_q;
        res_next_d   = '0;
        res_count_d  = count_q + 1'b1;
        res_status_d = sdll_pkg::STAT_OK;
        ptail_d      = tail_q;
        tail_d       = n_q;
        count_d      = count_q + 1'b1;
        in_list_d[n_q] = 1'b1;
        if (count_q == '0) begin
          head_d  = n_q;
          state_d = S_DONE;
        end else begin
          state_d = S_INS_TAIL;
        end
      end

      // Link the old tail forward to the new node
      S_INS_TAIL: begin
        nx_we    = 1'b1;
        nx_addr  = ptail_q;
        nx_wdata = n_q;
        state_d  = S_DONE;
      end

      // Unlink the node from its neighbors
      S_RM_RD: begin
        res_slot_d   = slot_q;
        res_data_d   = dt_rdata_q;
        res_prev_d   = pv_rdata_q;
        res_next_d   = nx_rdata_q;
        res_count_d  = count_q - 1'b1;
        res_status_d = sdll_pkg::STAT_OK;
        if (pv_rdata_q != '0) begin
          nx_we    = 1'b1;
          nx_addr  = pv_rdata_q;
          nx_wdata = nx_rdata_q;
        end
        if (nx_rdata_q != '0) begin
          pv_we    = 1'b1;
          pv_addr  = nx_rdata_q;
          pv_wdata = pv_rdata_q;
        end
        if (head_q == slot_q) begin
          head_d = nx_rdata_q;
        end
        if (tail_q == slot_q) begin
          tail_d = pv_rdata_q;
        end
        count_d = count_q - 1'b1;
        in_list_d[slot_q] = 1'b0;
        state_d = S_RM_PUSH;
      end

      // Push the freed slot on the free stack
      S_RM_PUSH: begin
        nx_we      = 1'b1;
        nx_addr    = slot_q;
        nx_wdata   = free_top_q;
        free_top_d = slot_q;
        state_d    = S_DONE;
      end

      // Follow the next link, then read the successor
      S_NX_RD: begin
        if (nx_rdata_q == '0) begin
          res_status_d = sdll_pkg::STAT_BAD_SLOT;
          state_d      = S_DONE;
        end else begin
          nx_addr = nx_rdata_q;
          pv_addr = nx_rdata_q;
          dt_addr = nx_rdata_q;
          slot_d  = nx_rdata_q;
          state_d = S_RD_OUT;
        end
      end

      S_RD_OUT: begin
        res_slot_d   = slot_q;
        res_data_d   = dt_rdata_q;
        res_prev_d   = pv_rdata_q;
        res_next_d   = nx_rdata_q;
        res_count_d  = count_q;
        res_status_d = sdll_pkg::STAT_OK;
        state_d      = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    o_slot_d    = o_slot_q;
    o_data_d    = o_data_q;
    o_prev_d    = o_prev_q;
    o_next_d    = o_next_q;
    o_count_d   = o_count_q;
    o_status_d  = o_status_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      o_slot_d    = res_slot_q;
      o_data_d    = res_data_q;
      o_prev_d    = res_prev_q;
      o_next_d    = res_next_q;
      o_count_d   = res_count_q;
      o_status_d  = res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      hw_q        <= '0;
      free_top_q  <= '0;
      in_list_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      hw_q        <= hw_d;
      free_top_q  <= free_top_d;
      in_list_q   <= in_list_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    n_q          <= n_d;
    ptail_q      <= ptail_d;
    din_q        <= din_d;
    res_slot_q   <= res_slot_d;
    res_data_q   <= res_data_d;
    res_prev_q   <= res_prev_d;
    res_next_q   <= res_next_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
    o_slot_q     <= o_slot_d;
    o_data_q     <= o_data_d;
    o_prev_q     <= o_prev_d;
    o_next_q     <= o_next_d;
    o_count_q    <= o_count_d;
    o_status_q   <= o_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign slot_out_o   = o_slot_q;
  assign data_out_o   = o_data_q;
  assign prev_out_o   = o_prev_q;
  assign next_out_o   = o_next_q;
  assign list_count_o = o_count_q;
  assign status_o     = o_status_q;

endmodule
